@@ rtl/gec_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gec_pkg
// Shared types and constants of the greedy edge color allocator.
// ----------------------------------------------------------------------------
package gec_pkg;

  localparam int NUM_NODES  = 1024;
  localparam int COLOR_BITS = 64;
  localparam int NODE_AW    = $clog2(NUM_NODES);
  localparam int CIDX_W     = $clog2(COLOR_BITS);

  localparam logic OP_COLOR = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic [6:0] MAX_COLORS_RST = 7'd64;

  typedef struct packed {
    logic       operation;
    logic [9:0] node_a;
    logic [9:0] node_b;
  } in_item_t;

  typedef struct packed {
    logic [5:0] edge_color;
    logic       no_free_color;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_READ  = 3'b010,
    ST_CLEAR = 3'b100
  } state_t;

endpackage

@@ rtl/gec_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gec_ram
// Generic true dual-port RAM, one clock, registered read on each port.
// ----------------------------------------------------------------------------
module gec_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     a_en,
  input  logic                     a_we,
  input  logic [$clog2(DEPTH)-1:0] a_addr,
  input  logic [WIDTH-1:0]         a_wdata,
  output logic [WIDTH-1:0]         a_rdata,
  input  logic                     b_en,
  input  logic                     b_we,
  input  logic [$clog2(DEPTH)-1:0] b_addr,
  input  logic [WIDTH-1:0]         b_wdata,
  output logic [WIDTH-1:0]         b_rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (a_en) begin
      if (a_we) begin
        mem[a_addr] <= a_wdata;
      end else begin
        a_rdata <= mem[a_addr];
      end
    end
    if (b_en) begin
      if (b_we) begin
        mem[b_addr] <= b_wdata;
      end else begin
        b_rdata <= mem[b_addr];
      end
    end
  end

endmodule

@@ rtl/greedy_edge_color_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_edge_color_allocator
// Per-node used-color masks with greedy lowest-free color pick per edge.
// ----------------------------------------------------------------------------
// An edge transaction reads both endpoint masks from a dual-port RAM in the
// accept cycle; once the output is free, the lowest color free at both ends
// (below max_colors, saturated at 64) is picked, both masks are written back
// and the result is registered. Clear transactions return their result at
// once, then sweep all 1024 mask RAM entries one entry a cycle with in_stall
// high; the same sweep runs after reset. Edges with no free color return
// no_free_color, masks unchanged. The user must write max_colors through
// cfg_we/cfg_wdata only while the block idles; the block does not enforce it.
// ----------------------------------------------------------------------------
module greedy_edge_color_allocator
  import gec_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic [6:0] cfg_wdata
);

  state_t               state_r, state_nxt;
  logic [NODE_AW-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [NODE_AW-1:0]   node_a_r, node_b_r;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r, out_data_nxt;
  logic [6:0]           max_colors_r;

  logic                 out_free, in_acc, out_of_range;
  logic                 a_en, a_we, b_en, b_we;
  logic [NODE_AW-1:0]   a_addr, b_addr;
  logic [COLOR_BITS-1:0] a_wdata, b_wdata, a_rdata, b_rdata;
  logic [COLOR_BITS-1:0] lim_mask, free_bits, pick_bit;
  logic [CIDX_W-1:0]    pick_idx;
  logic [6:0]           lim;
  logic                 found;

  assign out_free     = !out_valid_r || !out_stall;
  assign in_stall     = (state_r != ST_IDLE) || !out_free;
  assign in_acc       = in_valid && !in_stall;
  assign out_of_range = (int'(in_data.node_a) >= NUM_NODES) ||
                        (int'(in_data.node_b) >= NUM_NODES);
  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;

  // color pick over the two masks read when the edge was accepted
  assign lim = (max_colors_r > 7'(COLOR_BITS)) ? 7'(COLOR_BITS) : max_colors_r;

  always_comb begin
    for (int c = 0; c < COLOR_BITS; c++) begin
      lim_mask[c] = (c < int'(lim));
    end
  end

  assign free_bits = ~(a_rdata | b_rdata) & lim_mask;
  assign found     = |free_bits;
  // isolate lowest set bit
  assign pick_bit  = free_bits & (~free_bits + COLOR_BITS'(1));

  always_comb begin
    pick_idx = '0;
    for (int j = 0; j < CIDX_W; j++) begin
      for (int i = 0; i < COLOR_BITS; i++) begin
        if (((i >> j) & 1) == 1) begin
          pick_idx[j] = pick_idx[j] | pick_bit[i];
        end
      end
    end
  end

  assign a_wdata = (state_r == ST_CLEAR) ? '0 : (a_rdata | pick_bit);
  assign b_wdata = b_rdata | pick_bit;

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    a_en   = 1'b0;
    a_we   = 1'b0;
    b_en   = 1'b0;
    b_we   = 1'b0;
    a_addr = in_data.node_a[NODE_AW-1:0];
    b_addr = in_data.node_b[NODE_AW-1:0];
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data.operation == OP_CLEAR) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{edge_color: 6'd0, no_free_color: 1'b0};
            clr_cnt_nxt   = '0;
            state_nxt     = ST_CLEAR;
          end else if (out_of_range) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{edge_color: 6'd0, no_free_color: 1'b1};
          end else begin
            a_en      = 1'b1;
            b_en      = 1'b1;
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        a_addr = node_a_r;
        b_addr = node_b_r;
        if (out_free) begin
          a_en = found;
          a_we = found;
          // self loop writes one entry only
          b_en = found && (node_a_r != node_b_r);
          b_we = b_en;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{edge_color: found ? 6'(pick_idx) : 6'd0,
                            no_free_color: !found};
          state_nxt = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        a_addr      = clr_cnt_r;
        a_en        = 1'b1;
        a_we        = 1'b1;
        clr_cnt_nxt = clr_cnt_r + NODE_AW'(1);
        if (int'(clr_cnt_r) == NUM_NODES - 1) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
      max_colors_r <= MAX_COLORS_RST;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        max_colors_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (in_acc) begin
      node_a_r <= in_data.node_a[NODE_AW-1:0];
      node_b_r <= in_data.node_b[NODE_AW-1:0];
    end
  end

  gec_ram #(
    .WIDTH (COLOR_BITS),
    .DEPTH (NUM_NODES)
  ) u_mask_ram (
    .clk     (clk),
    .a_en    (a_en),
    .a_we    (a_we),
    .a_addr  (a_addr),
    .a_wdata (a_wdata),
    .a_rdata (a_rdata),
    .b_en    (b_en),
    .b_we    (b_we),
    .b_addr  (b_addr),
    .b_wdata (b_wdata),
    .b_rdata (b_rdata)
  );

endmodule

@@ rtl/gec_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gec_checker
// Port-level assertions for the greedy edge color allocator.
// ----------------------------------------------------------------------------
module gec_checker
  import gec_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input out_item_t  out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // a failed edge always reports color zero
  a_fail_zero: assert property (@(posedge clk)
    out_valid && out_data.no_free_color |-> out_data.edge_color == 6'd0)
    else $error("failure with nonzero color");

  a_rst_no_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // mask sweep after reset blocks input
  a_rst_sweep: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input taken during post-reset sweep");

endmodule

bind greedy_edge_color_allocator gec_checker u_gec_checker (.*);
